### hw/rtl/rhrc_pkg.sv
// ----------------------------------------------------------------------------
// rhrc_pkg: shared types for the rank histogram range counter
// Command format between front and back, state encodings, field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rhrc_pkg;

   localparam int BIN_W = 10;
   localparam int EMP_W = 10;
   localparam int CNT_W = 11;
   localparam int FIELD_DEPTH = 1024;  // 2**BIN_W, reachable entries

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_CHANGE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SUB,
      F_ADD,
      F_QRY
   } front_state_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_URD,
      B_UWR,
      B_QRD,
      B_QACC,
      B_DONE
   } back_state_type;

   // one unit of work for the back end
   typedef struct packed {
      logic             is_query;
      logic             dec;      // update: subtract one instead of add
      logic             empty;    // query: range holds no bins
      logic [BIN_W-1:0] a;        // update bin, or query low bound
      logic [BIN_W-1:0] b;        // query high bound (clamped)
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

### hw/rtl/rhrc_queue.sv
// ----------------------------------------------------------------------------
// rhrc_queue: command queue
// Four-entry FIFO between the front end and the tree engine.
// ----------------------------------------------------------------------------
`default_nettype none

module rhrc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  rhrc_pkg::cmd_type     push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  not_empty,
   output rhrc_pkg::cmd_type     pop_data
);

   rhrc_pkg::cmd_type slot_ff [0:3];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full      = (cnt_ff == 3'd4);
   assign not_empty = (cnt_ff != 3'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      cnt_in    = cnt_ff + {2'b0, do_push} - {2'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         cnt_ff    <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/rhrc_front.sv
// ----------------------------------------------------------------------------
// rhrc_front: request front end
// Accepts beats, tracks each employee's bin, issues tree commands.
// ----------------------------------------------------------------------------
`default_nettype none

module rhrc_front #(
   parameter int NUM_BINS      = 1024,
   parameter int NUM_EMPLOYEES = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_operation,
   input  wire logic [rhrc_pkg::EMP_W-1:0] req_employee,
   input  wire logic [rhrc_pkg::BIN_W-1:0] req_bin,
   input  wire logic [rhrc_pkg::BIN_W-1:0] req_range_low,
   input  wire logic [rhrc_pkg::BIN_W-1:0] req_range_high,
   input  rhrc_pkg::back_status_type       back_status,
   output logic                            q_push,
   output rhrc_pkg::cmd_type               q_data,
   input  wire logic                       q_full
);

   localparam int EMP_DEPTH = (NUM_EMPLOYEES < rhrc_pkg::FIELD_DEPTH) ?
                              NUM_EMPLOYEES : rhrc_pkg::FIELD_DEPTH;
   localparam int EW = (EMP_DEPTH > 1) ? $clog2(EMP_DEPTH) : 1;
   localparam int BIN_DEPTH = (NUM_BINS < rhrc_pkg::FIELD_DEPTH) ?
                              NUM_BINS : rhrc_pkg::FIELD_DEPTH;
   localparam logic [rhrc_pkg::BIN_W-1:0] BIN_LAST = rhrc_pkg::BIN_W'(BIN_DEPTH - 1);

   logic [rhrc_pkg::BIN_W-1:0] emp_mem [0:EMP_DEPTH-1];

   rhrc_pkg::front_state_type  state_ff, state_in;
   logic [EW-1:0]              emp_ff;
   logic [rhrc_pkg::BIN_W-1:0] bin_ff, lo_ff, hi_ff;
   logic [rhrc_pkg::BIN_W-1:0] old_ff;
   logic                       accept, emp_ok, new_ok, old_ok, emp_we;
   logic [rhrc_pkg::BIN_W-1:0] hi_clamp;

   assign accept   = req_valid && req_ready;
   assign emp_ok   = 32'(req_employee) < NUM_EMPLOYEES;
   assign new_ok   = 32'(bin_ff) < NUM_BINS;
   assign old_ok   = 32'(old_ff) < NUM_BINS;
   assign hi_clamp = (hi_ff > BIN_LAST) ? BIN_LAST : hi_ff;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      q_push    = 1'b0;
      emp_we    = 1'b0;
      q_data    = '0;
      unique case (state_ff)
         rhrc_pkg::F_IDLE: begin
            req_ready = !back_status.clearing;
            if (accept) begin
               priority if (req_operation == rhrc_pkg::OP_LOAD && emp_ok) begin
                  state_in = rhrc_pkg::F_ADD;
               end else if (req_operation == rhrc_pkg::OP_CHANGE && emp_ok) begin
                  state_in = rhrc_pkg::F_SUB;
               end else if (req_operation == rhrc_pkg::OP_QUERY) begin
                  state_in = rhrc_pkg::F_QRY;
               end else begin
                  state_in = rhrc_pkg::F_IDLE;
               end
            end
         end
         rhrc_pkg::F_SUB: begin
            q_data.dec = 1'b1;
            q_data.a   = old_ff;
            if (!old_ok) begin
               state_in = rhrc_pkg::F_ADD;
            end else if (!q_full) begin
               q_push   = 1'b1;
               state_in = rhrc_pkg::F_ADD;
            end
         end
         rhrc_pkg::F_ADD: begin
            q_data.a = bin_ff;
            if (!new_ok || !q_full) begin
               q_push   = new_ok;
               emp_we   = 1'b1;
               state_in = rhrc_pkg::F_IDLE;
            end
         end
         rhrc_pkg::F_QRY: begin
            q_data.is_query = 1'b1;
            q_data.empty    = lo_ff > hi_clamp;
            q_data.a        = lo_ff;
            q_data.b        = hi_clamp;
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = rhrc_pkg::F_IDLE;
            end
         end
         default: state_in = rhrc_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhrc_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         emp_ff <= req_employee[EW-1:0];
         bin_ff <= req_bin;
         lo_ff  <= req_range_low;
         hi_ff  <= req_range_high;
         old_ff <= emp_mem[req_employee[EW-1:0]];
      end
      if (emp_we) begin
         emp_mem[emp_ff] <= bin_ff;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/rhrc_back.sv
// ----------------------------------------------------------------------------
// rhrc_back: tree engine
// Fenwick tree of bin counts; point updates and range sums, one node a step.
// ----------------------------------------------------------------------------
`default_nettype none

module rhrc_back #(
   parameter int NUM_BINS = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_valid,
   input  rhrc_pkg::cmd_type               q_data,
   output logic                            q_pop,
   output rhrc_pkg::back_status_type       status,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [rhrc_pkg::CNT_W-1:0]      rsp_count
);

   localparam int N  = (NUM_BINS < rhrc_pkg::FIELD_DEPTH) ?
                       NUM_BINS : rhrc_pkg::FIELD_DEPTH;
   localparam int TW = $clog2(N + 1);
   localparam int PW = TW + 1;
   localparam logic [PW-1:0] LAST = PW'(N);
   localparam int CW = rhrc_pkg::CNT_W;

   logic [CW-1:0] tree_mem [0:N];
   logic [CW-1:0] rd_ff;

   rhrc_pkg::back_state_type state_ff, state_in;
   logic [PW-1:0] p_ff, p_in, k2_ff, k2_in, clr_ff, clr_in;
   logic          dec_ff, dec_in, phase_ff, phase_in;
   logic [CW-1:0] acc_ff, acc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;
   logic          we;
   logic [TW-1:0] waddr;
   logic [CW-1:0] wdata;
   logic [PW-1:0] low_bit, p_up;

   assign low_bit         = p_ff & (~p_ff + PW'(1));
   assign p_up            = p_ff + low_bit;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count       = rsp_count_ff;
   assign status.clearing = (state_ff == rhrc_pkg::B_CLEAR);

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      k2_in        = k2_ff;
      clr_in       = clr_ff;
      dec_in       = dec_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      q_pop        = 1'b0;
      we           = 1'b0;
      waddr        = p_ff[TW-1:0];
      wdata        = rd_ff + (dec_ff ? {CW{1'b1}} : CW'(1));
      unique case (state_ff)
         rhrc_pkg::B_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff[TW-1:0];
            wdata  = '0;
            clr_in = clr_ff + PW'(1);
            if (clr_ff == LAST) begin
               state_in = rhrc_pkg::B_IDLE;
            end
         end
         rhrc_pkg::B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (!q_data.is_query) begin
                  p_in     = PW'(q_data.a) + PW'(1);
                  dec_in   = q_data.dec;
                  state_in = rhrc_pkg::B_URD;
               end else if (q_data.empty) begin
                  acc_in   = '0;
                  state_in = rhrc_pkg::B_DONE;
               end else begin
                  p_in     = PW'(q_data.b) + PW'(1);
                  k2_in    = PW'(q_data.a);
                  phase_in = 1'b0;
                  acc_in   = '0;
                  state_in = rhrc_pkg::B_QRD;
               end
            end
         end
         rhrc_pkg::B_URD: state_in = rhrc_pkg::B_UWR;
         rhrc_pkg::B_UWR: begin
            we   = 1'b1;
            p_in = p_up;
            state_in = (p_up > LAST) ? rhrc_pkg::B_IDLE : rhrc_pkg::B_URD;
         end
         rhrc_pkg::B_QRD: begin
            if (p_ff == '0) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  p_in     = k2_ff;
               end else begin
                  state_in = rhrc_pkg::B_DONE;
               end
            end else begin
               state_in = rhrc_pkg::B_QACC;
            end
         end
         rhrc_pkg::B_QACC: begin
            acc_in   = phase_ff ? acc_ff - rd_ff : acc_ff + rd_ff;
            p_in     = p_ff - low_bit;
            state_in = rhrc_pkg::B_QRD;
         end
         rhrc_pkg::B_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = acc_ff;
               state_in     = rhrc_pkg::B_IDLE;
            end
         end
         default: state_in = rhrc_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhrc_pkg::B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      k2_ff        <= k2_in;
      dec_ff       <= dec_in;
      phase_ff     <= phase_in;
      acc_ff       <= acc_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         tree_mem[waddr] <= wdata;
      end
      rd_ff <= tree_mem[p_ff[TW-1:0]];
   end

endmodule

`default_nettype wire

### hw/rtl/rank_histogram_range_count_top.sv
// ----------------------------------------------------------------------------
// rank_histogram_range_count_top: employee count per salary bin, range query
// Front end, command queue and Fenwick tree engine.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel, one beat per item: operation 0 loads an employee into a
//    bin, 1 moves an employee to a new bin, 2 asks for the employee count
//    over bins range_low..range_high inclusive, 3 is ignored.
//  - rsp_* channel: one beat with count for every query, in request order;
//    loads and changes return nothing.
//  - Update work: an update walks up to log2(bins)+1 tree nodes, reading
//    then writing each node; a change does two such walks. A query walks
//    two prefix paths, reading then accumulating each node.
//  - The node walks of the tree engine set the rate; the front
//    end queues up to four commands so it can take the next beat while the
//    engine still works and while a response waits.
//  - Reset clears the tree with a pass over its NUM_BINS+1 entries (capped at
//    1025); req_ready stays low until it ends.
//  - A stalled rsp beat holds; the engine then halts at its next result
//    and the queue fills, after which req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_histogram_range_count_top #(
   parameter int NUM_BINS      = 1024,
   parameter int NUM_EMPLOYEES = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_operation,
   input  wire logic [rhrc_pkg::EMP_W-1:0] req_employee,
   input  wire logic [rhrc_pkg::BIN_W-1:0] req_bin,
   input  wire logic [rhrc_pkg::BIN_W-1:0] req_range_low,
   input  wire logic [rhrc_pkg::BIN_W-1:0] req_range_high,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [rhrc_pkg::CNT_W-1:0]      rsp_count
);

   rhrc_pkg::cmd_type         push_data, pop_data;
   rhrc_pkg::back_status_type back_status;
   logic push, full, pop, not_empty;

   // front: classify beats, keep each employee's bin
   rhrc_front #(
      .NUM_BINS      (NUM_BINS),
      .NUM_EMPLOYEES (NUM_EMPLOYEES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_employee   (req_employee),
      .req_bin        (req_bin),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .back_status    (back_status),
      .q_push         (push),
      .q_data         (push_data),
      .q_full         (full)
   );

   // decouples front and engine
   rhrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   // engine: tree walks and the response register
   rhrc_back #(
      .NUM_BINS (NUM_BINS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (not_empty),
      .q_data    (pop_data),
      .q_pop     (pop),
      .status    (back_status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_count (rsp_count)
   );

endmodule

`default_nettype wire

### hw/rtl/rhrc_checker.sv
// ----------------------------------------------------------------------------
// rhrc_checker: port checks
// Reset behavior and response hold, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rhrc_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [rhrc_pkg::CNT_W-1:0] rsp_count
);

   // clear pass blocks requests right after reset
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("request taken during clear pass");

   // no response can be pending out of reset
   a_no_rsp_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count))
      else $error("response dropped or changed under stall");

endmodule

bind rank_histogram_range_count_top rhrc_checker u_rhrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_count (rsp_count)
);

`default_nettype wire
